>>> sv/serial_command_deframer_macros.svh
// ----------------------------------------------------------------------------
// Serial command deframer assertion macros
// Immediate-style wrappers around concurrent assertions clocked on i_clk
// and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_DEFRAMER_MACROS_SVH
`define SERIAL_COMMAND_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCD_ASSERT_IMP(lbl, ante, cons, msg)
`define SCD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// Serial command deframer package
// Shared widths, character codes, result kinds and the result token type.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int PLEN_W      = 16;
    localparam int QDEPTH      = 2;
    localparam int QAW         = $clog2(QDEPTH);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam int         RADIX    = 10;

    typedef enum logic [2:0] {
        KIND_NAME      = 3'd0,
        KIND_TEXT      = 3'd1,
        KIND_BIN       = 3'd2,
        KIND_CMD_END   = 3'd3,
        KIND_TEXT_END  = 3'd4,
        KIND_EMPTY_END = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic               last;
        logic [PLEN_W-1:0]  plen;
    } t_token;

endpackage

`default_nettype wire

>>> sv/serial_command_deframer.sv
// ----------------------------------------------------------------------------
// Serial command deframer
// Splits a received serial byte stream into command name, text payload and
// length-prefixed binary payload results.
//
//   channel   dir  tdata                         tlast  tuser
//   s_axis    in   rx_byte[7:0]                  -      -
//   m_axis    out  data[7:0], payload_len[23:8]  last   kind[2:0]
//
// One byte accepted per cycle while the queue has room; the parser state updates on each accepted byte.
// A result passes through the queue, then the output register, to m_axis.
// A two-beat token queue decouples the parser from the output register.
// s_axis_tready drops only while the queue is full (sink stalled).
// Synchronous active-low reset returns the parser to name reading.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_deframer import scd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // data[7:0], payload_length[23:8]
    output      logic        m_axis_tlast,   // last
    output      logic [2:0]  m_axis_tuser    // kind[2:0]
);

    logic    push, pop, full, empty;
    t_token  tok_in, tok_head;

    scd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (full),
        .o_push        (push),
        .o_token       (tok_in)
    );

    scd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (tok_in),
        .i_pop   (pop),
        .o_head  (tok_head),
        .o_full  (full),
        .o_empty (empty)
    );

    scd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (tok_head),
        .i_empty       (empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> sv/scd_front.sv
// ----------------------------------------------------------------------------
// Serial command deframer front end
// Accepts received bytes, tracks the frame parse mode and length counters,
// and pushes one result token per byte that produces a result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_command_deframer_macros.svh"

module scd_front import scd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire logic        i_full,
    output      logic        o_push,
    output      t_token      o_token
);

    typedef enum logic [1:0] {
        MODE_NAME = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_SIZE = 2'd2,
        MODE_BIN  = 2'd3
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic                   emit;
    logic                   accept;
    logic [7:0]             ch;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && !i_full;
    assign o_push        = accept && emit;
    assign cnt_inc       = r_cnt + LENGTH_BITS'(1);

    always_comb begin
        n_mode       = r_mode;
        n_len        = r_len;
        n_cnt        = r_cnt;
        emit         = 1'b0;
        o_token.kind = KIND_NAME;
        o_token.data = ch;
        o_token.last = 1'b0;
        o_token.plen = '0;
        unique case (r_mode)
            MODE_NAME: begin
                priority if (ch == CH_COLON) begin
                    n_mode = MODE_TEXT;
                end else if (ch == CH_AT) begin
                    n_len  = '0;
                    n_cnt  = '0;
                    n_mode = MODE_SIZE;
                end else if (ch == CH_LF) begin
                    n_mode       = MODE_NAME;
                    n_len        = '0;
                    n_cnt        = '0;
                    emit         = 1'b1;
                    o_token.kind = KIND_CMD_END;
                    o_token.data = '0;
                    o_token.last = 1'b1;
                end else if (ch == CH_CR) begin
                    emit = 1'b0;
                end else begin
                    emit = 1'b1;
                end
            end
            MODE_TEXT: begin
                emit = 1'b1;
                if (ch == CH_LF) begin
                    n_mode       = MODE_NAME;
                    n_len        = '0;
                    n_cnt        = '0;
                    o_token.kind = KIND_TEXT_END;
                    o_token.data = '0;
                    o_token.last = 1'b1;
                end else begin
                    o_token.kind = KIND_TEXT;
                end
            end
            MODE_SIZE: begin
                if (ch == CH_HASH) begin
                    n_cnt = '0;
                    if (r_len == '0) begin
                        n_mode       = MODE_NAME;
                        emit         = 1'b1;
                        o_token.kind = KIND_EMPTY_END;
                        o_token.data = '0;
                        o_token.last = 1'b1;
                    end else begin
                        n_mode = MODE_BIN;
                    end
                end else begin
                    // x*10 plus the digit value, as shift-add, wraps to the length width
                    n_len = LENGTH_BITS'((r_len << 3) + (r_len << 1)
                                         + LENGTH_BITS'(ch) - LENGTH_BITS'(CH_ZERO));
                end
            end
            MODE_BIN: begin
                emit         = 1'b1;
                o_token.kind = KIND_BIN;
                o_token.plen = PLEN_W'(r_len);
                n_cnt        = cnt_inc;
                if (cnt_inc == r_len || r_len == '0) begin
                    o_token.last = 1'b1;
                    n_mode       = MODE_NAME;
                    n_len        = '0;
                    n_cnt        = '0;
                end
            end
            default: begin
                n_mode = MODE_NAME;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NAME;
            r_len  <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
        end
    end

    `SCD_ASSERT_IMP(a_bin_count, r_mode == MODE_BIN, r_len != '0 && r_cnt < r_len, "binary count out of range")
    `SCD_ASSERT_IMP(a_idle_clear, r_mode == MODE_NAME || r_mode == MODE_TEXT, r_len == '0 && r_cnt == '0, "counters not cleared outside binary frame")
    `SCD_ASSERT_IMP(a_size_cnt, r_mode == MODE_SIZE, r_cnt == '0, "count moved while reading length")
    `SCD_ASSERT_IMP(a_push_room, o_push, !i_full, "push into full queue")

endmodule

`default_nettype wire

>>> sv/scd_queue.sv
// ----------------------------------------------------------------------------
// Serial command deframer token queue
// Short show-ahead queue of result tokens between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_command_deframer_macros.svh"

module scd_queue import scd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_token  i_token,
    input  wire logic    i_pop,
    output      t_token  o_head,
    output      logic    o_full,
    output      logic    o_empty
);

    t_token           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `SCD_ASSERT_IMP(a_no_pop_empty, r_count == '0, !i_pop, "pop from empty queue")
    `SCD_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + (QAW+1)'(1), "queue count did not rise")
    `SCD_ASSERT_IMP(a_count_max, 1'b1, r_count <= (QAW+1)'(QDEPTH), "queue over depth")

endmodule

`default_nettype wire

>>> sv/scd_back.sv
// ----------------------------------------------------------------------------
// Serial command deframer back end
// Output register that drains the token queue onto the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_back import scd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_token      i_head,
    input  wire logic        i_empty,
    output      logic        o_pop,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // data[7:0], payload_length[23:8]
    output      logic        m_axis_tlast,   // last
    output      logic [2:0]  m_axis_tuser    // kind[2:0]
);

    logic    r_valid;
    t_token  r_tok;

    assign o_pop         = !i_empty && (!r_valid || m_axis_tready);
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_tok.plen, r_tok.data};
    assign m_axis_tlast  = r_tok.last;
    assign m_axis_tuser  = r_tok.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || m_axis_tready) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tok <= i_head;
        end
    end

endmodule

`default_nettype wire
